### rtl/trm_pkg.sv
// Shared definitions for the tiny register machine execute unit.
// Holds field widths, operation and status codes, and the controller/datapath structs.
// No dependencies; imported by every other file in rtl/.
`default_nettype none

package trm_pkg;

    // Fixed field widths of one instruction item and one result item.
    localparam int OP_W       = 4;
    localparam int REGNUM_W   = 3;
    localparam int WORD_W     = 32;
    localparam int TARGET_W   = 10;
    localparam int STATUS_W   = 2;

    // Packed input item: operation, dest, first sel/reg/imm, second sel/reg/imm, target.
    localparam int IN_BITS    = OP_W + REGNUM_W + 2 * (1 + REGNUM_W + WORD_W) + TARGET_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Defaults for the top-level parameters.
    localparam int NUM_REGS_DEF = 8;
    localparam int INDEX_W_DEF  = 10;

    // Operation codes; anything above OP_LOAD is illegal.
    localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
    localparam logic [OP_W-1:0] OP_B    = 4'd4;
    localparam logic [OP_W-1:0] OP_BEQ  = 4'd5;
    localparam logic [OP_W-1:0] OP_BNE  = 4'd6;
    localparam logic [OP_W-1:0] OP_END  = 4'd7;
    localparam logic [OP_W-1:0] OP_LOAD = 4'd8;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ILLEGAL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic read_regs;
        logic execute;
        logic finish;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_run;
        logic div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/tiny_register_machine_execute_unit.sv
// Top level of the tiny register machine execute unit.
// Depends on trm_pkg, trm_ctrl, trm_dpath (and trm_div below it).
//
// Usage: each item on the slave stream is one decoded instruction. It is executed against a
// file of NUM_REGS 32-bit registers and an INDEX_WIDTH-bit program index, and exactly one
// result item leaves on the master stream for every item taken in, in order.
// Sequence: each accepted item passes through register read, execute and finish, and its
// result is then offered. A division with a non-zero divisor adds a divide step between
// execute and finish, in which the divider produces one quotient bit per cycle. One item is
// worked on at a time; the next item can be accepted from the cycle after the previous one
// has been finished.
// The result sits in an output register, so a new item is taken in while an earlier result
// is still waiting for the receiver.
// When the receiver stalls, the finished result holds in the output register and the item
// being worked on waits in its finish step until the register is free; nothing is lost.
// Reset (synchronous, active low) clears the program index, marks every register as zero
// through per-entry valid bits, and empties the output register; no clearing pass is needed.
// Registers numbered at or above NUM_REGS read as zero and writes to them are dropped.
`default_nettype none

module tiny_register_machine_execute_unit
    import trm_pkg::*;
#(
    parameter int NUM_REGS    = NUM_REGS_DEF,
    parameter int INDEX_WIDTH = INDEX_W_DEF,
    localparam int OUT_BITS    = INDEX_WIDTH + 1 + REGNUM_W + WORD_W + STATUS_W,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // From bit 0 up: operation, dest_reg, first_is_immediate, first_reg, first_immediate,
    // second_is_immediate, second_reg, second_immediate, branch_target, zero padding.
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // From bit 0 up: next_index, reg_written, written_reg, written_value, status,
    // zero padding.
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Input field positions within tdata.
    localparam int P_OP    = 0;
    localparam int P_DST   = P_OP + OP_W;
    localparam int P_AIS   = P_DST + REGNUM_W;
    localparam int P_AREG  = P_AIS + 1;
    localparam int P_AIMM  = P_AREG + REGNUM_W;
    localparam int P_BIS   = P_AIMM + WORD_W;
    localparam int P_BREG  = P_BIS + 1;
    localparam int P_BIMM  = P_BREG + REGNUM_W;
    localparam int P_TGT   = P_BIMM + WORD_W;

    t_ctrl_cmd cmd;
    t_dp_sts   sts;

    logic [INDEX_WIDTH-1:0] next_index;
    logic                   reg_written;
    logic [REGNUM_W-1:0]    written_reg;
    logic [WORD_W-1:0]      written_value;
    logic [STATUS_W-1:0]    status;

    trm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    trm_dpath #(
        .NUM_REGS    (NUM_REGS),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .i_operation           (s_axis_tdata[P_OP   +: OP_W]),
        .i_dest_reg            (s_axis_tdata[P_DST  +: REGNUM_W]),
        .i_first_is_immediate  (s_axis_tdata[P_AIS]),
        .i_first_reg           (s_axis_tdata[P_AREG +: REGNUM_W]),
        .i_first_immediate     (s_axis_tdata[P_AIMM +: WORD_W]),
        .i_second_is_immediate (s_axis_tdata[P_BIS]),
        .i_second_reg          (s_axis_tdata[P_BREG +: REGNUM_W]),
        .i_second_immediate    (s_axis_tdata[P_BIMM +: WORD_W]),
        .i_branch_target       (s_axis_tdata[P_TGT  +: TARGET_W]),
        .o_next_index          (next_index),
        .o_reg_written         (reg_written),
        .o_written_reg         (written_reg),
        .o_written_value       (written_value),
        .o_status              (status)
    );

    assign m_axis_tdata = OUT_TDATA_W'({status, written_value, written_reg, reg_written,
                                        next_index});

endmodule

`default_nettype wire

### rtl/trm_div.sv
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// Depends on trm_pkg for the word width.
`default_nettype none

module trm_div
    import trm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WORD_W-1:0] i_dividend,
    input  wire logic [WORD_W-1:0] i_divisor,
    output logic                   o_done,
    output logic      [WORD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_dvs;
    logic              r_neg;

    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;
    logic              step_ok;

    // Restoring step: bring in the next dividend bit and try to subtract.
    assign shifted = {r_rem, r_quo[WORD_W-1]};
    assign trial   = shifted - {1'b0, r_dvs};
    assign step_ok = ~trial[WORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[WORD_W-1] ? -i_dividend : i_dividend;
            r_dvs <= i_divisor[WORD_W-1] ? -i_divisor : i_divisor;
            r_neg <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
        end else if (r_busy) begin
            r_rem <= step_ok ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], step_ok};
        end
    end

    assign o_done     = r_busy && (r_cnt == LAST_STEP);
    assign o_quotient = r_neg ? -r_quo : r_quo;

endmodule

`default_nettype wire

### rtl/trm_dpath.sv
// Datapath of the execute unit: item register, register file, ALU, divider, program index
// and result register. Depends on trm_pkg and trm_div.
`default_nettype none

module trm_dpath
    import trm_pkg::*;
#(
    parameter int NUM_REGS    = NUM_REGS_DEF,
    parameter int INDEX_WIDTH = INDEX_W_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_ctrl_cmd              i_cmd,
    output t_dp_sts                     o_sts,
    input  wire logic [OP_W-1:0]        i_operation,
    input  wire logic [REGNUM_W-1:0]    i_dest_reg,
    input  wire logic                   i_first_is_immediate,
    input  wire logic [REGNUM_W-1:0]    i_first_reg,
    input  wire logic [WORD_W-1:0]      i_first_immediate,
    input  wire logic                   i_second_is_immediate,
    input  wire logic [REGNUM_W-1:0]    i_second_reg,
    input  wire logic [WORD_W-1:0]      i_second_immediate,
    input  wire logic [TARGET_W-1:0]    i_branch_target,
    output logic      [INDEX_WIDTH-1:0] o_next_index,
    output logic                        o_reg_written,
    output logic      [REGNUM_W-1:0]    o_written_reg,
    output logic      [WORD_W-1:0]      o_written_value,
    output logic      [STATUS_W-1:0]    o_status
);

    localparam int RA_W  = $clog2(NUM_REGS);
    localparam int EXT_W = RA_W + REGNUM_W;
    localparam logic [EXT_W-1:0] REG_LIMIT = EXT_W'(NUM_REGS);
    localparam int TGT_EXT_W = INDEX_WIDTH + TARGET_W;

    function automatic logic reg_in_range(input logic [REGNUM_W-1:0] num);
        return EXT_W'(num) < REG_LIMIT;
    endfunction

    function automatic logic [RA_W-1:0] reg_addr(input logic [REGNUM_W-1:0] num);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(num);
        return ext[RA_W-1:0];
    endfunction

    // Latched instruction item.
    logic [OP_W-1:0]     r_op;
    logic [REGNUM_W-1:0] r_dst;
    logic                r_a_is_imm;
    logic [REGNUM_W-1:0] r_a_reg;
    logic [WORD_W-1:0]   r_a_imm;
    logic                r_b_is_imm;
    logic [REGNUM_W-1:0] r_b_reg;
    logic [WORD_W-1:0]   r_b_imm;
    logic [TARGET_W-1:0] r_target;

    // Register file with a valid bit per entry; an entry not yet written reads as zero.
    logic [WORD_W-1:0]   r_rf [NUM_REGS];
    logic [NUM_REGS-1:0] r_rf_valid;
    logic [WORD_W-1:0]   r_rd_a;
    logic [WORD_W-1:0]   r_rd_b;

    // Execute results.
    logic [WORD_W-1:0]   r_value;
    logic                r_wr_op;
    logic                r_branch;
    logic                r_div0;
    logic                r_illegal;
    logic                r_use_quo;
    logic [WORD_W-1:0]   n_value;
    logic                n_wr_op;
    logic                n_branch;
    logic                n_div0;
    logic                n_illegal;
    logic                n_use_quo;

    logic [INDEX_WIDTH-1:0] r_pc;

    logic [WORD_W-1:0]      op_a;
    logic [WORD_W-1:0]      op_b;
    logic                   div_done;
    logic [WORD_W-1:0]      quotient;
    logic                   fin_write;
    logic [WORD_W-1:0]      fin_value;
    logic [INDEX_WIDTH-1:0] fin_next;
    logic [STATUS_W-1:0]    fin_status;
    logic [TGT_EXT_W-1:0]   tgt_ext;
    logic [RA_W-1:0]        a_addr;
    logic [RA_W-1:0]        b_addr;
    logic [RA_W-1:0]        w_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op       <= i_operation;
            r_dst      <= i_dest_reg;
            r_a_is_imm <= i_first_is_immediate;
            r_a_reg    <= i_first_reg;
            r_a_imm    <= i_first_immediate;
            r_b_is_imm <= i_second_is_immediate;
            r_b_reg    <= i_second_reg;
            r_b_imm    <= i_second_immediate;
            r_target   <= i_branch_target;
        end
    end

    assign a_addr = reg_addr(r_a_reg);
    assign b_addr = reg_addr(r_b_reg);
    assign w_addr = reg_addr(r_dst);

    // Registered reads at the two operand addresses.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read_regs) begin
            if (reg_in_range(r_a_reg) && r_rf_valid[a_addr]) begin
                r_rd_a <= r_rf[a_addr];
            end else begin
                r_rd_a <= '0;
            end
            if (reg_in_range(r_b_reg) && r_rf_valid[b_addr]) begin
                r_rd_b <= r_rf[b_addr];
            end else begin
                r_rd_b <= '0;
            end
        end
    end

    assign op_a = r_a_is_imm ? r_a_imm : r_rd_a;
    assign op_b = r_b_is_imm ? r_b_imm : r_rd_b;

    always_comb begin
        n_value   = '0;
        n_wr_op   = 1'b0;
        n_branch  = 1'b0;
        n_div0    = 1'b0;
        n_illegal = 1'b0;
        n_use_quo = 1'b0;
        unique case (r_op)
            OP_ADD: begin
                n_value = op_a + op_b;
                n_wr_op = 1'b1;
            end
            OP_SUB: begin
                n_value = op_a - op_b;
                n_wr_op = 1'b1;
            end
            OP_MUL: begin
                n_value = op_a * op_b;
                n_wr_op = 1'b1;
            end
            OP_DIV: begin
                n_div0    = (op_b == '0);
                n_wr_op   = (op_b != '0);
                n_use_quo = (op_b != '0);
            end
            OP_B: begin
                n_branch = 1'b1;
            end
            OP_BEQ: begin
                n_branch = (op_a == op_b);
            end
            OP_BNE: begin
                n_branch = (op_a != op_b);
            end
            OP_END: begin
                n_branch = 1'b0;
            end
            OP_LOAD: begin
                n_value = r_b_imm;
                n_wr_op = 1'b1;
            end
            default: begin
                n_illegal = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_value   <= n_value;
            r_wr_op   <= n_wr_op;
            r_branch  <= n_branch;
            r_div0    <= n_div0;
            r_illegal <= n_illegal;
            r_use_quo <= n_use_quo;
        end
    end

    assign o_sts.div_run  = (r_op == OP_DIV) && (op_b != '0);
    assign o_sts.div_done = div_done;

    trm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.execute && o_sts.div_run),
        .i_dividend (op_a),
        .i_divisor  (op_b),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Final result assembly.
    assign tgt_ext    = TGT_EXT_W'(r_target);
    assign fin_write  = r_wr_op && reg_in_range(r_dst);
    assign fin_value  = r_use_quo ? quotient : r_value;
    assign fin_next   = r_div0   ? r_pc :
                        r_branch ? tgt_ext[INDEX_WIDTH-1:0] :
                                   r_pc + INDEX_WIDTH'(1);
    assign fin_status = r_illegal ? ST_ILLEGAL :
                        r_div0    ? ST_DIV_ZERO : ST_OK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_rf_valid <= '0;
        end else if (i_cmd.finish) begin
            r_pc <= fin_next;
            if (fin_write) begin
                r_rf_valid[w_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && fin_write) begin
            r_rf[w_addr] <= fin_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_next_index    <= fin_next;
            o_reg_written   <= fin_write;
            o_written_reg   <= fin_write ? r_dst : '0;
            o_written_value <= fin_write ? fin_value : '0;
            o_status        <= fin_status;
        end
    end

endmodule

`default_nettype wire

### rtl/trm_ctrl.sv
// Controller of the execute unit: sequences one item through read, execute, divide (for a division) and finish,
// and owns the result valid flag. Depends on trm_pkg.
`default_nettype none

module trm_ctrl
    import trm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_ctrl_cmd    o_cmd,
    input  wire t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    assign o_cmd.load_item = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.read_regs = (r_state == S_READ);
    assign o_cmd.execute   = (r_state == S_EXEC);
    assign o_cmd.finish    = (r_state == S_FIN) && out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= i_sts.div_run ? S_DIV : S_FIN;
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A result is only committed into a free output slot.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result finished into an occupied output register");

    // The divider only completes while the controller waits for it.
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_DIV))
        else $error("divider completed outside the divide state");

    // A non-divide item goes straight from execute to finish.
    a_exec_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !i_sts.div_run) |=> (r_state == S_FIN))
        else $error("non-divide item did not move to finish");

    // A new result only appears straight after the finish state.
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result valid raised outside finish");

endmodule

`default_nettype wire

### test/tiny_register_machine_execute_unit_tb.sv
// Self-checking testbench for the tiny register machine execute unit.
// Needs trm_pkg and the execute unit RTL; a built-in predictor supplies the expected result items.
`timescale 1ns / 1ps

module tiny_register_machine_execute_unit_tb;
    import trm_pkg::*;

    // The cycle limit is several times the slowest run: about 975 items, each at most a
    // division plus random gaps on both sides.
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 950;
    localparam int DRAIN_CYCLES = 40;

    // Operation codes above OP_LOAD are illegal.
    localparam logic [OP_W-1:0] OP_BAD_FIRST = 4'd9;
    localparam logic [OP_W-1:0] OP_BAD_LAST  = 4'd15;

    // One instruction item as packed into s_axis_tdata; the first member is the top bits.
    typedef struct packed {
        logic [6:0]          pad;
        logic [TARGET_W-1:0] target;
        logic [WORD_W-1:0]   second_imm;
        logic [REGNUM_W-1:0] second_reg;
        logic                second_sel;
        logic [WORD_W-1:0]   first_imm;
        logic [REGNUM_W-1:0] first_reg;
        logic                first_sel;
        logic [REGNUM_W-1:0] dest;
        logic [OP_W-1:0]     op;
    } instr_t;

    // One result item as packed into m_axis_tdata.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   value;
        logic [REGNUM_W-1:0] wreg;
        logic                written;
        logic [TARGET_W-1:0] next_index;
    } result_t;

    // Predicts the result of every instruction taken in and checks the results that leave.
    class register_machine_predictor;
        logic [WORD_W-1:0]   regs [8];
        logic [TARGET_W-1:0] pc_index;
        result_t             expected_results [$];
        int executed, divisions, zero_divides, taken_branches, illegal_ops;
        int compared, mismatches;

        function new();
            foreach (regs[i]) regs[i] = '0;
            pc_index = '0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_instruction(instr_t ins);
            logic [WORD_W-1:0]   a, b;
            logic [TARGET_W-1:0] nxt;
            longint              quotient;
            result_t             r;
            bit                  taken;
            a = ins.first_sel ? ins.first_imm : regs[ins.first_reg];
            b = ins.second_sel ? ins.second_imm : regs[ins.second_reg];
            nxt = pc_index + 1'b1;
            r = '0;
            taken = 0;
            case (ins.op)
                OP_ADD: begin
                    r.value = a + b;
                    r.written = 1'b1;
                end
                OP_SUB: begin
                    r.value = a - b;
                    r.written = 1'b1;
                end
                OP_MUL: begin
                    r.value = a * b;
                    r.written = 1'b1;
                end
                OP_DIV: begin
                    divisions++;
                    if (b == '0) begin
                        // The index stays where it is and nothing is written.
                        r.status = ST_DIV_ZERO;
                        nxt = pc_index;
                        zero_divides++;
                    end else begin
                        // Worked in 64 bits so that the most negative value over minus one
                        // wraps instead of trapping.
                        quotient = longint'($signed(a)) / longint'($signed(b));
                        r.value = quotient[31:0];
                        r.written = 1'b1;
                    end
                end
                OP_B:   taken = 1;
                OP_BEQ: taken = (a == b);
                OP_BNE: taken = (a != b);
                OP_END: ;
                OP_LOAD: begin
                    r.value = ins.second_imm;
                    r.written = 1'b1;
                end
                default: begin
                    r.status = ST_ILLEGAL;
                    illegal_ops++;
                end
            endcase
            if (taken) begin
                nxt = ins.target;
                taken_branches++;
            end
            if (r.written) begin
                r.wreg = ins.dest;
                regs[ins.dest] = r.value;
            end
            pc_index = nxt;
            r.next_index = nxt;
            executed++;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result item, expected none, actual %h", $time, got);
                return;
            end
            want = expected_results.pop_front();
            compared++;
            compare_field("next_index", 32'(want.next_index), 32'(got.next_index));
            compare_field("reg_written", 32'(want.written), 32'(got.written));
            compare_field("written_reg", 32'(want.wreg), 32'(got.wreg));
            compare_field("written_value", want.value, got.value);
            compare_field("status", 32'(want.status), 32'(got.status));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // From bit 0 up: operation, dest_reg, first_is_immediate, first_reg, first_immediate,
    // second_is_immediate, second_reg, second_immediate, branch_target, zero padding.
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // From bit 0 up: next_index, reg_written, written_reg, written_value, status.
    logic [47:0]            m_axis_tdata;

    // When set, neither side inserts idle cycles.
    bit steady = 0;
    int cycle_count = 0;

    register_machine_predictor book = new();

    tiny_register_machine_execute_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls at random, except during the steady stretch.
    always @(negedge i_clk) begin
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 14);
    end

    // Results are sampled at the rising edge, when the handshake completes.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            book.check_result(result_t'(m_axis_tdata));
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, book.pending());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic instr_t make_instr(logic [3:0] op, logic [2:0] dest,
                                          logic fsel, logic [2:0] freg, logic [31:0] fimm,
                                          logic ssel, logic [2:0] sreg, logic [31:0] simm,
                                          logic [9:0] target);
        instr_t ins;
        ins = '0;
        ins.op = op;
        ins.dest = dest;
        ins.first_sel = fsel;
        ins.first_reg = freg;
        ins.first_imm = fimm;
        ins.second_sel = ssel;
        ins.second_reg = sreg;
        ins.second_imm = simm;
        ins.target = target;
        return ins;
    endfunction

    // Operand values lean towards the awkward ones: zero, one, minus one and both extremes.
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic instr_t random_instruction();
        instr_t ins;
        ins = '0;
        ins.dest = REGNUM_W'($urandom_range(0, 7));
        ins.first_sel = 1'($urandom_range(0, 1));
        ins.first_reg = REGNUM_W'($urandom_range(0, 7));
        ins.first_imm = random_word();
        ins.second_sel = 1'($urandom_range(0, 1));
        ins.second_reg = REGNUM_W'($urandom_range(0, 7));
        ins.second_imm = random_word();
        ins.target = TARGET_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 99) < 8) begin
            ins.op = OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
        end else if ($urandom_range(0, 99) < 20) begin
            ins.op = OP_LOAD;
        end else begin
            ins.op = OP_W'($urandom_range(OP_ADD, OP_END));
        end
        // Equal operands now and then, so that conditional branches go both ways.
        if ((ins.op == OP_BEQ || ins.op == OP_BNE) && $urandom_range(0, 1)) begin
            ins.second_sel = ins.first_sel;
            ins.second_reg = ins.first_reg;
            ins.second_imm = ins.first_imm;
        end
        return ins;
    endfunction

    // Offers one item, with random idle cycles first, and returns at the falling edge
    // after it was accepted. tvalid stays high if the next item follows at once.
    task automatic send_instruction(input instr_t ins);
        while (!steady && $urandom_range(0, 99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ins;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        book.note_instruction(ins);
        @(negedge i_clk);
    endtask

    // Holds the sender off until every expected result has arrived.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (book.pending() != 0);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: extremes of the operands, every operation and the special cases.
        send_instruction(make_instr(OP_LOAD, 3'd1, 1'b1, 3'd7, 32'hFFFF_FFFF,
                                    1'b0, 3'd0, 32'h7FFF_FFFF, 10'd0));
        send_instruction(make_instr(OP_LOAD, 3'd2, 1'b0, 3'd0, 32'h0,
                                    1'b1, 3'd7, 32'h8000_0000, 10'd1023));
        send_instruction(make_instr(OP_LOAD, 3'd3, 1'b0, 3'd0, 32'h0,
                                    1'b0, 3'd0, 32'hFFFF_FFFF, 10'd0));
        send_instruction(make_instr(OP_LOAD, 3'd7, 1'b0, 3'd0, 32'h0,
                                    1'b0, 3'd0, 32'h0000_0001, 10'd0));
        // Signed overflow on add, sub and mul.
        send_instruction(make_instr(OP_ADD, 3'd4, 1'b0, 3'd1, 32'h0,
                                    1'b1, 3'd0, 32'h0000_0001, 10'd0));
        send_instruction(make_instr(OP_SUB, 3'd5, 1'b0, 3'd2, 32'h0,
                                    1'b0, 3'd7, 32'h0, 10'd0));
        send_instruction(make_instr(OP_SUB, 3'd6, 1'b1, 3'd0, 32'h0,
                                    1'b0, 3'd1, 32'h0, 10'd0));
        send_instruction(make_instr(OP_MUL, 3'd6, 1'b0, 3'd1, 32'h0,
                                    1'b0, 3'd1, 32'h0, 10'd0));
        // Most negative over minus one wraps; a negative quotient truncates toward zero.
        send_instruction(make_instr(OP_DIV, 3'd7, 1'b0, 3'd2, 32'h0,
                                    1'b0, 3'd3, 32'h0, 10'd0));
        send_instruction(make_instr(OP_DIV, 3'd4, 1'b1, 3'd0, 32'hFFFF_FFF9,
                                    1'b1, 3'd0, 32'h0000_0002, 10'd0));
        // Divide by zero, from a register and from an immediate.
        send_instruction(make_instr(OP_DIV, 3'd5, 1'b0, 3'd1, 32'h0,
                                    1'b0, 3'd0, 32'h0, 10'd0));
        send_instruction(make_instr(OP_DIV, 3'd5, 1'b1, 3'd0, 32'h1234_5678,
                                    1'b1, 3'd0, 32'h0, 10'd0));
        // A taken branch to the top index, then an add that wraps the index to zero.
        send_instruction(make_instr(OP_BEQ, 3'd0, 1'b0, 3'd1, 32'h0,
                                    1'b0, 3'd1, 32'h0, 10'd1023));
        send_instruction(make_instr(OP_ADD, 3'd0, 1'b1, 3'd0, 32'hFFFF_FFFF,
                                    1'b1, 3'd0, 32'hFFFF_FFFF, 10'd0));
        send_instruction(make_instr(OP_BEQ, 3'd0, 1'b0, 3'd1, 32'h0,
                                    1'b0, 3'd2, 32'h0, 10'd5));
        send_instruction(make_instr(OP_BNE, 3'd0, 1'b0, 3'd1, 32'h0,
                                    1'b0, 3'd2, 32'h0, 10'h155));
        send_instruction(make_instr(OP_BNE, 3'd0, 1'b1, 3'd0, 32'h8000_0000,
                                    1'b1, 3'd0, 32'h8000_0000, 10'h2AA));
        // Unconditional branch and end ignore their operand fields.
        send_instruction(make_instr(OP_B, 3'd7, 1'b1, 3'd7, 32'hFFFF_FFFF,
                                    1'b1, 3'd7, 32'hFFFF_FFFF, 10'h2AA));
        send_instruction(make_instr(OP_END, 3'd7, 1'b1, 3'd7, 32'hFFFF_FFFF,
                                    1'b0, 3'd7, 32'hFFFF_FFFF, 10'h3FF));
        send_instruction(make_instr(OP_BAD_FIRST, 3'd3, 1'b0, 3'd1, 32'h0,
                                    1'b0, 3'd2, 32'h0, 10'd7));
        send_instruction(make_instr(OP_BAD_LAST, 3'd7, 1'b1, 3'd7, 32'hFFFF_FFFF,
                                    1'b1, 3'd7, 32'hFFFF_FFFF, 10'h3FF));
        send_instruction(make_instr(OP_LOAD, 3'd0, 1'b1, 3'd7, 32'hFFFF_FFFF,
                                    1'b1, 3'd7, 32'h0, 10'h3FF));
        wait_drained();

        // Random part, with a long stretch where neither side idles.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 300 && n < 550);
            if (n == 700) wait_drained();
            send_instruction(random_instruction());
        end
        steady = 0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Executed %0d instructions: %0d divisions (%0d by zero), %0d taken branches,",
                 book.executed, book.divisions, book.zero_divides, book.taken_branches);
        $display("%0d illegal operations; %0d results compared, %0d mismatches.",
                 book.illegal_ops, book.compared, book.mismatches);
        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
rtl/trm_pkg.sv
rtl/trm_div.sv
rtl/trm_dpath.sv
rtl/trm_ctrl.sv
rtl/tiny_register_machine_execute_unit.sv
test/tiny_register_machine_execute_unit_tb.sv
